// File: rtl/ipv6lpr_pkg.sv
// Types, codes and helpers shared by the route table, its cells and channels.
// No dependencies.
`default_nettype none

package ipv6lpr_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int IF_W            = 8;
   localparam int TIME_W          = 32;
   localparam int LEN_W           = 8;
   localparam int COUNT_OUT_W     = 7;

   localparam logic [LEN_W-1:0] MAX_LEN        = LEN_W'(128);
   localparam logic [15:0]      MANUAL_METRIC  = 16'd10;
   localparam logic [15:0]      PREFIX_METRIC  = 16'd0;
   localparam logic [7:0]       PREFIX_DIST    = 8'd0;

   typedef enum logic [2:0] {
      KIND_LOOKUP = 3'd0,
      KIND_ADD    = 3'd1,
      KIND_UPDATE = 3'd2,
      KIND_DELP   = 3'd3,
      KIND_DELIF  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISS    = 2'd1,
      ST_FULL    = 2'd2,
      ST_NOTHING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SRC_MANUAL = 2'd0,
      SRC_RA     = 2'd1,
      SRC_OWN    = 2'd2,
      SRC_PROTO  = 2'd3
   } route_src_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_UPDATE,
      CELL_KILL,
      CELL_TAKE_RIGHT,
      CELL_TAKE_LEFT
   } cell_cmd_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_COMPACT,
      FSM_SORT,
      FSM_FINISH
   } fsm_type;

   localparam logic ADDR_ADMIN = 1'b0;

   typedef struct packed {
      logic [63:0]       pre_hi;
      logic [63:0]       pre_lo;
      logic [LEN_W-1:0]  len;
      logic [1:0]        src;
      logic [IF_W-1:0]   ifc;
      logic [63:0]       hop_hi;
      logic [63:0]       hop_lo;
      logic [15:0]       metric;
      logic [7:0]        adm_dist;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   typedef struct packed {
      logic [63:0]       addr_hi;
      logic [63:0]       addr_lo;
      logic [LEN_W-1:0]  len;
      logic [1:0]        src;
      logic [IF_W-1:0]   ifc;
      logic [TIME_W-1:0] expiry;
      logic [TIME_W-1:0] now;
      logic              use_dist;
   } query_type;

   typedef struct packed {
      logic match;
      logic expired;
      logic is_ra;
      logic exact;
      logic ifc_eq;
      logic beats_left;
   } cell_status_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [63:0]       addr_high;
      logic [63:0]       addr_low;
      logic [7:0]        prefix_length;
      logic [1:0]        source_type;
      logic [7:0]        interface_id;
      logic [63:0]       next_hop_high;
      logic [63:0]       next_hop_low;
      logic [15:0]       route_metric;
      logic [7:0]        admin_distance;
      logic [TIME_W-1:0] expiry_time;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [7:0]             out_interface;
      logic [63:0]            out_next_hop_high;
      logic [63:0]            out_next_hop_low;
      logic [7:0]             out_prefix_length;
      logic [15:0]            out_metric;
      logic [COUNT_OUT_W-1:0] entries_in_use;
   } rsp_type;

   // Saturate a prefix length at the full address width.
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ipv6lpr_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on ipv6lpr_pkg.
`default_nettype none

interface ipv6lpr_req_if;
   import ipv6lpr_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/ipv6lpr_rsp_if.sv
// Response channel: valid/ready handshake carrying one response word.
// Depends on ipv6lpr_pkg.
`default_nettype none

interface ipv6lpr_rsp_if;
   import ipv6lpr_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/ipv6_longest_prefix_route_table.sv
// IPv6 longest-prefix route table: a chain of route cells kept packed and sorted.
// Lookup and delete: the accepted word is executed, holes left by removed entries
// are closed (compaction), and the finish state builds the response word.
// Add, and update of an absent prefix: execute, transposition sort, finish; in-place
// update, full table or unknown kind: execute, finish. One request at a time.
// A new word is taken while the response waits; synchronous reset empties the table.
`default_nettype none

module ipv6_longest_prefix_route_table #(
   parameter int TABLE_DEPTH = ipv6lpr_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ipv6lpr_req_if.sink      req_port,
   ipv6lpr_rsp_if.source    rsp_port,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import ipv6lpr_pkg::*;

   localparam int N     = TABLE_DEPTH;
   localparam int CNT_W = $clog2(N + 1);
   localparam int PASS_W = $clog2(N);

   logic use_dist;

   ipv6lpr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .use_dist (use_dist)
   );

   fsm_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [1:0]  status_ff, status_in;
   entry_type   hit_ff, hit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   query_type       query;
   entry_type       new_entry;
   entry_type       ent   [N];
   cell_status_type st    [N];
   cell_cmd_type    cmd   [N];
   logic [N-1:0]    v;
   logic [N-1:0]    hit, exact, first_exact, first_hit, new_slot, boundary, gap;
   logic [N:0]      hit_before, exact_before, hole_upto;
   logic [N:0]      swap;
   logic            full, any_exact, any_hit, any_ifc, gap_any;
   logic [CNT_W-1:0] count;
   entry_type       hit_sel;

   // Query seen by all cells
   always_comb begin
      query.addr_hi  = req_ff.addr_high;
      query.addr_lo  = req_ff.addr_low;
      query.len      = clamp_len(req_ff.prefix_length);
      query.src      = req_ff.source_type;
      query.ifc      = IF_W'(req_ff.interface_id);
      query.expiry   = req_ff.expiry_time;
      query.now      = req_ff.now;
      query.use_dist = use_dist;
   end

   // Route built from the request
   always_comb begin
      new_entry.pre_hi = req_ff.addr_high;
      new_entry.pre_lo = req_ff.addr_low;
      new_entry.len    = clamp_len(req_ff.prefix_length);
      new_entry.src    = req_ff.source_type;
      new_entry.ifc    = IF_W'(req_ff.interface_id);
      new_entry.expiry = req_ff.expiry_time;
      if (req_ff.kind == KIND_ADD) begin
         new_entry.hop_hi   = req_ff.next_hop_high;
         new_entry.hop_lo   = req_ff.next_hop_low;
         new_entry.metric   = req_ff.route_metric;
         new_entry.adm_dist = req_ff.admin_distance;
         if ((req_ff.source_type == SRC_MANUAL) && (req_ff.route_metric == 16'd0)) begin
            new_entry.metric = MANUAL_METRIC;
         end
      end else begin
         new_entry.hop_hi   = 64'd0;
         new_entry.hop_lo   = 64'd0;
         new_entry.metric   = PREFIX_METRIC;
         new_entry.adm_dist = PREFIX_DIST;
      end
   end

   // Cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      ipv6lpr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd[i]),
         .query       (query),
         .new_entry   (new_entry),
         .left_entry  (ent[(i == 0) ? 0 : i - 1]),
         .right_entry (ent[(i == N - 1) ? i : i + 1]),
         .right_valid ((i == N - 1) ? 1'b0 : v[(i == N - 1) ? i : i + 1]),
         .entry       (ent[i]),
         .valid       (v[i]),
         .status      (st[i])
      );
   end

   // Per-cell flags and the priority tokens that ripple down the chain
   always_comb begin
      hit_before[0]   = 1'b0;
      exact_before[0] = 1'b0;
      hole_upto[0]    = 1'b0;
      for (int i = 0; i < N; i++) begin
         hit[i]   = v[i] && st[i].match && !st[i].expired;
         exact[i] = v[i] && st[i].exact;
         hit_before[i+1]   = hit_before[i] | hit[i];
         exact_before[i+1] = exact_before[i] | exact[i];
         hole_upto[i+1]    = hole_upto[i] | !v[i];
         first_hit[i]   = hit[i] && !hit_before[i];
         first_exact[i] = exact[i] && !exact_before[i];
         new_slot[i]    = !v[i] && ((i == 0) ? 1'b1 : v[(i == 0) ? 0 : i - 1]);
         boundary[i]    = v[i] && ((i == N - 1) ? 1'b1 : !v[(i == N - 1) ? i : i + 1]);
         gap[i]         = (i == N - 1) ? 1'b0 : (!v[i] && v[(i == N - 1) ? i : i + 1]);
      end
      any_hit   = hit_before[N];
      any_exact = exact_before[N];
      full      = v[N-1];
      gap_any   = |gap;
      any_ifc   = 1'b0;
      for (int i = 0; i < N; i++) begin
         any_ifc = any_ifc | (v[i] && st[i].ifc_eq);
      end
   end

   // Select the winning route and count the packed entries
   always_comb begin
      hit_sel = '0;
      count   = '0;
      for (int i = 0; i < N; i++) begin
         hit_sel = hit_sel | (ent[i] & {$bits(entry_type){first_hit[i]}});
         count   = count | (CNT_W'(i + 1) & {CNT_W{boundary[i]}});
      end
   end

   // Odd-even transposition pairs: pair (i-1, i) is active when i[0] differs from phase
   always_comb begin
      swap[0] = 1'b0;
      swap[N] = 1'b0;
      for (int i = 1; i < N; i++) begin
         swap[i] = (state_ff == FSM_SORT) && ((i % 2 == 1) != pass_ff[0]) &&
                   v[i-1] && v[i] && st[i].beats_left;
      end
   end

   // Cell commands
   always_comb begin
      for (int i = 0; i < N; i++) begin
         cmd[i] = CELL_HOLD;
         unique case (state_ff)
            FSM_EXEC: begin
               case (req_ff.kind)
                  KIND_LOOKUP: begin
                     if (v[i] && st[i].match && st[i].expired && st[i].is_ra && !hit_before[i]) begin
                        cmd[i] = CELL_KILL;
                     end
                  end
                  KIND_ADD: begin
                     if (!full && new_slot[i]) begin
                        cmd[i] = CELL_LOAD;
                     end
                  end
                  KIND_UPDATE: begin
                     if (first_exact[i]) begin
                        cmd[i] = CELL_UPDATE;
                     end else if (!any_exact && !full && new_slot[i]) begin
                        cmd[i] = CELL_LOAD;
                     end
                  end
                  KIND_DELP: begin
                     if (first_exact[i]) begin
                        cmd[i] = CELL_KILL;
                     end
                  end
                  KIND_DELIF: begin
                     if (v[i] && st[i].ifc_eq) begin
                        cmd[i] = CELL_KILL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            FSM_COMPACT: begin
               if (gap_any && hole_upto[i+1]) begin
                  cmd[i] = CELL_TAKE_RIGHT;
               end
            end
            FSM_SORT: begin
               if (swap[i]) begin
                  cmd[i] = CELL_TAKE_LEFT;
               end else if (swap[i+1]) begin
                  cmd[i] = CELL_TAKE_RIGHT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign req_port.ready = (state_ff == FSM_IDLE);

   // Sequencer: next state, request capture, pending result, response register
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pass_in      = pass_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_port.valid) begin
               req_in   = req_port.payload;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            pass_in  = '0;
            hit_in   = '0;
            state_in = FSM_FINISH;
            case (req_ff.kind)
               KIND_LOOKUP: begin
                  status_in = any_hit ? ST_OK : ST_MISS;
                  hit_in    = hit_sel;
                  state_in  = FSM_COMPACT;
               end
               KIND_ADD: begin
                  status_in = full ? ST_FULL : ST_OK;
                  state_in  = full ? FSM_FINISH : FSM_SORT;
               end
               KIND_UPDATE: begin
                  status_in = (!any_exact && full) ? ST_FULL : ST_OK;
                  state_in  = (any_exact || full) ? FSM_FINISH : FSM_SORT;
               end
               KIND_DELP: begin
                  status_in = any_exact ? ST_OK : ST_NOTHING;
                  state_in  = FSM_COMPACT;
               end
               KIND_DELIF: begin
                  status_in = any_ifc ? ST_OK : ST_NOTHING;
                  state_in  = FSM_COMPACT;
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         FSM_COMPACT: begin
            if (!gap_any) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_SORT: begin
            pass_in = pass_ff + PASS_W'(1);
            if (pass_ff == PASS_W'(N - 1)) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_in.status                = status_ff;
               rsp_in.out_interface         = 8'(hit_ff.ifc);
               rsp_in.out_next_hop_high     = hit_ff.hop_hi;
               rsp_in.out_next_hop_low      = hit_ff.hop_lo;
               rsp_in.out_prefix_length     = hit_ff.len;
               rsp_in.out_metric            = hit_ff.metric;
               rsp_in.entries_in_use        = COUNT_OUT_W'(count);
               state_in                     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_ff;

   // Table stays packed whenever no request is in flight
   a_packed_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_IDLE) |-> !gap_any)
      else $error("route table has a hole while idle");

   // Packed table has at most one end marker
   a_one_boundary: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_IDLE) |-> $onehot0(boundary))
      else $error("route table end marker not unique");

   // Accepted word is executed next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> (state_ff == FSM_EXEC))
      else $error("accepted word not executed");

   // Sorting only ever runs after an add or update that found room
   a_sort_entry: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == FSM_SORT) && ($past(state_ff) == FSM_EXEC)) |-> v[0])
      else $error("sort started on empty table");
endmodule

`default_nettype wire

// File: rtl/ipv6lpr_csr.sv
// APB-style configuration register block (admin distance ordering switch).
// Depends on ipv6lpr_pkg.
`default_nettype none

module ipv6lpr_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic             use_dist
);
   import ipv6lpr_pkg::*;

   logic use_dist_ff, use_dist_in;
   logic sel_admin;

   // Register index sits above the byte offset
   assign sel_admin = (paddr[2] == ADDR_ADMIN);

   // Take a write on the access phase
   always_comb begin
      use_dist_in = use_dist_ff;
      if (psel && penable && pwrite && sel_admin) begin
         use_dist_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_dist_ff <= 1'b0;
      end else begin
         use_dist_ff <= use_dist_in;
      end
   end

   assign pready   = 1'b1;
   assign prdata   = (sel_admin && (paddr[1:0] == 2'd0)) ? {31'd0, use_dist_ff} : 32'd0;
   assign use_dist = use_dist_ff;
endmodule

`default_nettype wire

// File: rtl/ipv6lpr_cell.sv
// One route slot of the table chain: holds an entry, compares it against the
// current query and its left neighbor, and loads from either neighbor.
// Depends on ipv6lpr_pkg.
`default_nettype none

module ipv6lpr_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ipv6lpr_pkg::cell_cmd_type     cmd,
   input  wire ipv6lpr_pkg::query_type        query,
   input  wire ipv6lpr_pkg::entry_type        new_entry,
   input  wire ipv6lpr_pkg::entry_type        left_entry,
   input  wire ipv6lpr_pkg::entry_type        right_entry,
   input  wire logic                          right_valid,
   output ipv6lpr_pkg::entry_type             entry,
   output logic                               valid,
   output ipv6lpr_pkg::cell_status_type       status
);
   import ipv6lpr_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic [127:0] mask;
   logic [127:0] diff;

   // Build the prefix mask, most significant bit first
   always_comb begin
      for (int k = 0; k < 128; k++) begin
         mask[k] = (LEN_W'(127 - k) < entry_ff.len);
      end
   end

   assign diff = {query.addr_hi ^ entry_ff.pre_hi, query.addr_lo ^ entry_ff.pre_lo};

   // Compare against query and left neighbor
   always_comb begin
      status.match   = ((diff & mask) == 128'd0);
      status.expired = (entry_ff.expiry != '0) && (query.now > entry_ff.expiry);
      status.is_ra   = (entry_ff.src == SRC_RA);
      status.exact   = (entry_ff.src == query.src) && (entry_ff.pre_hi == query.addr_hi) &&
                       (entry_ff.pre_lo == query.addr_lo) && (entry_ff.len == query.len);
      status.ifc_eq  = (entry_ff.ifc == query.ifc);
      if (entry_ff.len != left_entry.len) begin
         status.beats_left = entry_ff.len > left_entry.len;
      end else if (query.use_dist && (entry_ff.adm_dist != left_entry.adm_dist)) begin
         status.beats_left = entry_ff.adm_dist < left_entry.adm_dist;
      end else begin
         status.beats_left = entry_ff.metric < left_entry.metric;
      end
   end

   // Apply the command for this cycle
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (cmd)
         CELL_LOAD: begin
            entry_in = new_entry;
            valid_in = 1'b1;
         end
         CELL_UPDATE: begin
            entry_in.ifc    = query.ifc;
            entry_in.expiry = query.expiry;
         end
         CELL_KILL: begin
            valid_in = 1'b0;
         end
         CELL_TAKE_RIGHT: begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
         CELL_TAKE_LEFT: begin
            entry_in = left_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
endmodule

`default_nettype wire

// File: test/tb_route_model.sv
// Route table predictor and result store for the IPv6 longest-prefix route table bench.
// Depends on ipv6lpr_pkg.
`default_nettype none

package tb_route_model_pkg;
   import ipv6lpr_pkg::*;

   localparam int DEPTH = 64;

   typedef struct {
      logic [63:0] pre_hi, pre_lo, hop_hi, hop_lo;
      logic [7:0]  len;
      logic [1:0]  src;
      logic [7:0]  ifc;
      logic [15:0] metric;
      logic [7:0]  adm_dist;
      logic [31:0] expiry;
   } route_t;

   class route_scoreboard;
      route_t  routes[$];
      bit      use_dist;
      rsp_type pending[$];
      int      mismatches;

      function void clear();
         routes.delete();
         use_dist = 0;
         pending.delete();
         mismatches = 0;
      endfunction

      function bit ranks_ahead(route_t a, route_t b);
         if (a.len != b.len) return a.len > b.len;
         if (use_dist && a.adm_dist != b.adm_dist) return a.adm_dist < b.adm_dist;
         return a.metric < b.metric;
      endfunction

      // append then stable insertion sort
      function status_type append_route(route_t r);
         route_t key;
         int j;
         if (routes.size() >= DEPTH) return ST_FULL;
         routes = {routes, r};
         for (int i = 1; i < routes.size(); i++) begin
            key = routes[i];
            j = i;
            while (j > 0 && ranks_ahead(key, routes[j-1])) begin
               routes[j] = routes[j-1];
               j--;
            end
            routes[j] = key;
         end
         return ST_OK;
      endfunction

      function bit prefix_hit(logic [63:0] ah, logic [63:0] al, route_t r);
         logic [127:0] mask, a, p;
         mask = (r.len == 0) ? '0 : ~128'd0 << (128 - r.len);
         a = {ah, al};
         p = {r.pre_hi, r.pre_lo};
         return ((a ^ p) & mask) == 0;
      endfunction

      function int find_exact(logic [1:0] s, logic [63:0] h, logic [63:0] l, logic [7:0] n);
         foreach (routes[i])
            if (routes[i].src == s && routes[i].pre_hi == h && routes[i].pre_lo == l &&
                routes[i].len == n) return i;
         return -1;
      endfunction

      // note an accepted request word, queue its expected response
      function void note_request(req_type q);
         rsp_type o;
         route_t  r;
         logic [7:0] n;
         int i, pos;
         o = '0;
         o.status = ST_OK;
         n = (q.prefix_length > 128) ? 8'd128 : q.prefix_length;
         r.pre_hi = q.addr_high; r.pre_lo = q.addr_low; r.len = n;
         r.src = q.source_type; r.ifc = q.interface_id; r.expiry = q.expiry_time;
         r.hop_hi = '0; r.hop_lo = '0; r.metric = '0; r.adm_dist = '0;
         case (q.kind)
            KIND_LOOKUP: begin
               o.status = ST_MISS;
               i = 0;
               while (i < routes.size()) begin
                  if (!prefix_hit(q.addr_high, q.addr_low, routes[i])) begin
                     i++;
                  end else if (routes[i].expiry != 0 && q.now > routes[i].expiry) begin
                     if (routes[i].src == SRC_RA) routes.delete(i);
                     else i++;
                  end else begin
                     o.status = ST_OK;
                     o.out_interface = routes[i].ifc;
                     o.out_next_hop_high = routes[i].hop_hi;
                     o.out_next_hop_low = routes[i].hop_lo;
                     o.out_prefix_length = routes[i].len;
                     o.out_metric = routes[i].metric;
                     break;
                  end
               end
            end
            KIND_ADD: begin
               r.hop_hi = q.next_hop_high; r.hop_lo = q.next_hop_low;
               r.metric = q.route_metric;
               if (q.source_type == SRC_MANUAL && r.metric == 0) r.metric = MANUAL_METRIC;
               r.adm_dist = q.admin_distance;
               o.status = append_route(r);
            end
            KIND_UPDATE: begin
               pos = find_exact(q.source_type, q.addr_high, q.addr_low, n);
               if (pos >= 0) begin
                  routes[pos].ifc = q.interface_id;
                  routes[pos].expiry = q.expiry_time;
               end else begin
                  o.status = append_route(r);
               end
            end
            KIND_DELP: begin
               pos = find_exact(q.source_type, q.addr_high, q.addr_low, n);
               if (pos >= 0) routes.delete(pos);
               else o.status = ST_NOTHING;
            end
            KIND_DELIF: begin
               o.status = ST_NOTHING;
               i = 0;
               while (i < routes.size()) begin
                  if (routes[i].ifc == q.interface_id) begin
                     routes.delete(i);
                     o.status = ST_OK;
                  end else begin
                     i++;
                  end
               end
            end
            default: ;
         endcase
         o.entries_in_use = 7'(routes.size());
         pending = {pending, o};
      endfunction

      // compare a response word with the oldest expectation
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected %h, got %h", want, got);
         end
      endfunction
   endclass
endpackage

`default_nettype wire

// File: test/tb_top.sv
// Top-level bench: drives requests, config writes and response stalls into the route table.
// Depends on ipv6lpr_pkg, the channel interfaces and tb_route_model_pkg.
`default_nettype none

module tb_top;
   import ipv6lpr_pkg::*;
   import tb_route_model_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   ipv6lpr_req_if req_ch();
   ipv6lpr_rsp_if rsp_ch();

   route_scoreboard board;
   req_type pool[16];
   int      issued;

   ipv6_longest_prefix_route_table u_dut (
      .clock(clock), .reset(reset), .req_port(req_ch.sink), .rsp_port(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   // watchdog
   initial begin
      #60000000;
      $display("ipv6_longest_prefix_route_table test failed");
      $finish;
   end

   // stall the response side at random; check each response word
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0) w = 0;
         if (w > 0) begin
            rsp_ch.ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         board.check_response(rsp_ch.payload);
      end
   end

   task automatic write_admin(bit v);
      psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= {31'd0, v};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      board.use_dist = v;
   endtask

   // hold valid across back-to-back words; drop it only during an idle gap
   task automatic send_word(req_type q);
      int w;
      w = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
         req_ch.valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(q);
      issued++;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_ch.valid <= 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type random_word();
      req_type q;
      int pick;
      q = '0;
      q.kind = $urandom_range(0, 9) < 4 ? KIND_LOOKUP : 3'($urandom_range(0, 4));
      if ($urandom_range(0, 40) == 0) q.kind = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 2) == 0) begin
         pick = $urandom_range(0, 15);
         q.addr_high = pool[pick].addr_high;
         q.addr_low = pool[pick].addr_low;
         if (q.kind == KIND_LOOKUP) q.addr_low ^= 64'($urandom);
         q.prefix_length = pool[pick].prefix_length;
         q.source_type = pool[pick].source_type;
      end else begin
         q.addr_high = rand64();
         q.addr_low = rand64();
         q.prefix_length = $urandom_range(0, 9) == 0 ? 8'($urandom_range(129, 255))
                                                      : 8'($urandom_range(0, 128));
         q.source_type = 2'($urandom_range(0, 3));
      end
      q.interface_id = $urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 7));
      q.next_hop_high = rand64();
      q.next_hop_low = rand64();
      q.route_metric = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
      q.admin_distance = 8'($urandom);
      q.expiry_time = $urandom_range(0, 2) == 0 ? 32'd0 : $urandom;
      q.now = $urandom;
      return q;
   endfunction

   initial begin
      req_type q;
      board = new();
      board.clear();
      issued = 0;
      foreach (pool[i]) begin
         pool[i] = '0;
         pool[i].addr_high = rand64();
         pool[i].addr_low = rand64();
         pool[i].prefix_length = $urandom_range(0, 4) == 0 ? 8'd0
                                                           : 8'($urandom_range(1, 130));
         pool[i].source_type = 2'($urandom_range(0, 3));
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every kind, special cases
      q = '0;
      send_word(q);                                 // lookup on empty table
      q.kind = KIND_DELP; send_word(q);             // delete finds nothing
      q.kind = KIND_DELIF; send_word(q);
      q.kind = KIND_ADD; q.source_type = SRC_MANUAL; q.prefix_length = 0;
      q.interface_id = 8'hff; q.next_hop_high = '1; q.next_hop_low = '1;
      send_word(q);                                 // manual default metric
      q.kind = KIND_ADD; q.addr_high = '1; q.addr_low = '1; q.prefix_length = 8'hff;
      q.source_type = SRC_PROTO; q.route_metric = 16'hffff; q.admin_distance = 8'hff;
      q.interface_id = 1; send_word(q);             // length above 128
      q.kind = KIND_ADD; q.source_type = SRC_RA; q.prefix_length = 64;
      q.expiry_time = 32'd100; q.route_metric = 5; q.interface_id = 2; send_word(q);
      q.kind = KIND_LOOKUP; q.now = 32'd50; send_word(q);
      q.kind = KIND_LOOKUP; q.now = 32'hffffffff; send_word(q);  // expired advert kept behind live hit
      q.kind = KIND_UPDATE; q.source_type = SRC_OWN; q.expiry_time = 32'd7;
      q.interface_id = 3; send_word(q);             // new prefix
      q.interface_id = 4; q.expiry_time = 32'hffffffff; send_word(q);  // update in place
      q.kind = KIND_LOOKUP; q.now = 0; send_word(q);
      q.kind = KIND_ADD; q.source_type = SRC_PROTO; q.expiry_time = 32'd1;
      q.prefix_length = 128; send_word(q);
      q.kind = KIND_LOOKUP; q.now = 32'd2; send_word(q);          // expired non-advert skipped
      q.kind = 3'd5; send_word(q);
      q.kind = 3'd7; send_word(q);
      q.kind = KIND_DELP; q.source_type = SRC_OWN; q.prefix_length = 64; send_word(q);
      q.kind = KIND_DELIF; q.interface_id = 8'hff; send_word(q);
      // fill to the brim, then add past it
      for (int k = 0; k < 66; k++) begin
         q = random_word();
         q.kind = KIND_ADD;
         q.interface_id = 9;
         send_word(q);
      end
      q.kind = KIND_UPDATE; q.addr_high = 64'h1234; send_word(q);
      q.kind = KIND_DELIF; q.interface_id = 9; send_word(q);
      drain();

      // random phases over both ordering settings
      for (int ph = 0; ph < 6; ph++) begin
         write_admin(ph[0]);
         for (int k = 0; k < 300; k++) send_word(random_word());
         drain();
      end
      write_admin(0);

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("ipv6_longest_prefix_route_table test passed");
      else
         $display("ipv6_longest_prefix_route_table test failed");
      $finish;
   end
endmodule

`default_nettype wire
